@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the palette search RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset
`define NPCS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("npcs assertion failed");

// Antecedent implies consequent in the same cycle
`define NPCS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("npcs implication failed");

// Antecedent implies consequent in the next cycle
`define NPCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("npcs next-cycle implication failed");

`endif

@@ rtl/npcs_pkg.sv @@
// ----------------------------------------------------------------------------
// npcs_pkg
// Types, widths and helpers shared by the palette search cells and top level.
// ----------------------------------------------------------------------------
package npcs_pkg;

  // Field widths
  localparam int unsigned COMP_W  = 8;   // one color component
  localparam int unsigned STORE_W = 6;   // stored component, VGA precision
  localparam int unsigned PAD_W   = COMP_W - STORE_W;
  localparam int unsigned IDX_W   = 8;   // palette index
  localparam int unsigned SQ_W    = 2 * COMP_W;
  localparam int unsigned DIST_W  = 18;  // sum of three squares

  // Starting distance, above any reachable distance, so the first cell wins
  localparam logic [DIST_W-1:0] DIST_INIT = '1;

  // Opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Palette write broadcast to every cell
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   index;
    logic [STORE_W-1:0] red;
    logic [STORE_W-1:0] green;
    logic [STORE_W-1:0] blue;
  } wr_t;

  // Lookup word handed from cell to cell
  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic [IDX_W-1:0]  best_index;
    logic [DIST_W-1:0] best_dist;
  } query_t;

  // Square of an absolute component difference
  function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
                                              input logic [COMP_W-1:0] b);
    logic [COMP_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return SQ_W'(d) * SQ_W'(d);
  endfunction

endpackage

@@ rtl/npcs_cell.sv @@
// ----------------------------------------------------------------------------
// npcs_cell
// One palette entry: holds its color, scores the passing lookup word against
// it and hands the updated best match to the next cell.
// ----------------------------------------------------------------------------
module npcs_cell #(
  parameter int unsigned CELL_INDEX = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  npcs_pkg::wr_t   wr_i,
  input  logic            valid_i,
  input  npcs_pkg::query_t data_i,
  output logic            valid_o,
  output npcs_pkg::query_t data_o
);
  import npcs_pkg::*;

  logic [STORE_W-1:0] red_q, green_q, blue_q;
  logic               valid_q;
  query_t             data_q, data_d;
  logic [DIST_W-1:0]  cand_dist;
  logic               hit;

  // Entry storage, cleared to black at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q   <= '0;
      green_q <= '0;
      blue_q  <= '0;
    end else if (wr_i.en && (wr_i.index == IDX_W'(CELL_INDEX))) begin
      red_q   <= wr_i.red;
      green_q <= wr_i.green;
      blue_q  <= wr_i.blue;
    end
  end

  // Squared distance to the passing color
  assign cand_dist = DIST_W'(sq_diff(data_i.red,   {red_q,   {PAD_W{1'b0}}}))
                   + DIST_W'(sq_diff(data_i.green, {green_q, {PAD_W{1'b0}}}))
                   + DIST_W'(sq_diff(data_i.blue,  {blue_q,  {PAD_W{1'b0}}}));

  // Strict less-than keeps the lowest index on ties
  assign hit = cand_dist < data_i.best_dist;

  always_comb begin
    data_d = data_i;
    if (hit) begin
      data_d.best_index = IDX_W'(CELL_INDEX);
      data_d.best_dist  = cand_dist;
    end
  end

  // Hand-off to the neighbor; the whole row holds while adv_i is low
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/nearest_palette_color_search_top.sv @@
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top
// Palette of RGB entries in a row of cells. A lookup word walks the row one
// cell per cycle while not frozen, leaving with the nearest entry and distance.
//
//   channel | valid      | stall      | payload
//   --------+------------+------------+------------------------------------
//   in      | in_valid_i | in_stall_o | opcode, entry_index, red/green/blue
//   out     | out_valid_o| out_stall_i| best_index, best_distance
//
// A lookup word is registered in each cell in turn, first to last, and then
// in the output register. One lookup is in the row at a time; the input
// stalls until it leaves. The entries reset to black, with no clearing pass.
// A stalled output freezes the row once the next finished word reaches its end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_palette_color_search_top #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [npcs_pkg::IDX_W-1:0]  entry_index_i,
  input  logic [npcs_pkg::COMP_W-1:0] red_i,
  input  logic [npcs_pkg::COMP_W-1:0] green_i,
  input  logic [npcs_pkg::COMP_W-1:0] blue_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [npcs_pkg::IDX_W-1:0]  best_index_o,
  output logic [npcs_pkg::DIST_W-1:0] best_distance_o
);
  import npcs_pkg::*;

  localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(195075);

  logic                     busy_q;
  logic                     accept;
  logic                     adv;
  logic                     load;
  wr_t                      wr;
  logic [PALETTE_ENTRIES:0] valid_c;
  query_t                   data_c [PALETTE_ENTRIES+1];
  logic                     out_valid_q;
  query_t                   out_q;

  // Input handshake
  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;

  // Palette write broadcast
  assign wr.en    = accept && (opcode_i == OP_WRITE);
  assign wr.index = entry_index_i;
  assign wr.red   = red_i[COMP_W-1:PAD_W];
  assign wr.green = green_i[COMP_W-1:PAD_W];
  assign wr.blue  = blue_i[COMP_W-1:PAD_W];

  // Lookup word entering the row
  assign valid_c[0]           = accept && (opcode_i == OP_LOOKUP);
  assign data_c[0].red        = red_i;
  assign data_c[0].green      = green_i;
  assign data_c[0].blue       = blue_i;
  assign data_c[0].best_index = '0;
  assign data_c[0].best_dist  = DIST_INIT;

  // Row freezes only when the finished word cannot move into the output
  assign adv  = !(valid_c[PALETTE_ENTRIES] && out_valid_q && out_stall_i);
  assign load = valid_c[PALETTE_ENTRIES] && adv;

  // Row of cells, one per palette entry
  for (genvar g = 0; g < PALETTE_ENTRIES; g++) begin : g_cell
    npcs_cell #(
      .CELL_INDEX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .wr_i   (wr),
      .valid_i(valid_c[g]),
      .data_i (data_c[g]),
      .valid_o(valid_c[g+1]),
      .data_o (data_c[g+1])
    );
  end

  // Busy from lookup accept until its word leaves the row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (valid_c[0]) begin
      busy_q <= 1'b1;
    end else if (load) begin
      busy_q <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= data_c[PALETTE_ENTRIES];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign best_index_o    = out_q.best_index;
  assign best_distance_o = out_q.best_dist;

  // Checks
  `NPCS_ASSERT(a_one_lookup, clk_i, rst_ni, $countones(valid_c) <= 1)
  `NPCS_ASSERT_IMPL(a_row_busy, clk_i, rst_ni, |valid_c[PALETTE_ENTRIES:1], busy_q)
  `NPCS_ASSERT_NEXT(a_tail_holds, clk_i, rst_ni, valid_c[PALETTE_ENTRIES] && !adv,
                    valid_c[PALETTE_ENTRIES] && $stable(data_c[PALETTE_ENTRIES]))
  `NPCS_ASSERT_IMPL(a_dist_range, clk_i, rst_ni, load,
                    data_c[PALETTE_ENTRIES].best_dist <= DIST_MAX)

endmodule
